// ----- rtl/trp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and character coding functions for the text run-length packer.
// Used by trp_front, trp_fifo, trp_back and text_rle_5bit_packer; depends on nothing.

package trp_pkg;

  // Code values and run limits.
  localparam logic [4:0] CodeMark     = 5'd31;
  localparam logic [4:0] CodeSpace    = 5'd26;
  localparam logic [4:0] CodePeriod   = 5'd27;
  localparam logic [4:0] CodeComma    = 5'd28;
  localparam logic [4:0] CodeNewline  = 5'd29;
  localparam logic [4:0] CodeQuestion = 5'd30;
  localparam logic [5:0] MinRun       = 6'd4;
  localparam logic [5:0] MaxRunChunk  = 6'd34;

  // Default depth of the queue between the front and back parts.
  localparam int unsigned FifoDepth = 4;

  // Up to three codes, first code in the top bits, with the number of valid codes.
  typedef struct packed {
    logic [14:0] codes;
    logic [1:0]  cnt;
  } grp_t;

  // One queue entry: up to five codes, first code in the top bits, unused codes zero.
  typedef struct packed {
    logic [24:0] codes;
    logic [2:0]  cnt;
    logic        flush;
  } qent_t;

  // Fold lower-case letters to upper case.
  function automatic logic [7:0] fold_char(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

  // Map a folded character to its 5-bit code.
  function automatic logic [4:0] char_code(logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    d = c - 8'h41;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = d[4:0];
    end else begin
      unique case (c)
        8'h20:   r = CodeSpace;
        8'h2E:   r = CodePeriod;
        8'h2C:   r = CodeComma;
        8'h0A:   r = CodeNewline;
        8'h3F:   r = CodeQuestion;
        default: r = CodeMark;
      endcase
    end
    return r;
  endfunction

  // Codes written when a run of the given code and length is closed.
  function automatic grp_t close_run(logic [4:0] code, logic [5:0] len);
    grp_t       g;
    logic [5:0] lm3;
    lm3 = len - 6'd3;
    g.codes = '0;
    g.cnt   = 2'd0;
    if (len == 6'd0 || code == CodeMark) begin
      g.cnt = 2'd0;
    end else if (len >= MinRun) begin
      g.codes = {CodeMark, code, lm3[4:0]};
      g.cnt   = 2'd3;
    end else if (len == 6'd1) begin
      g.codes = {code, 10'd0};
      g.cnt   = 2'd1;
    end else if (len == 6'd2) begin
      g.codes = {code, code, 5'd0};
      g.cnt   = 2'd2;
    end else begin
      g.codes = {code, code, code};
      g.cnt   = 2'd3;
    end
    return g;
  endfunction

endpackage

// ----- rtl/trp_fifo.sv -----
`timescale 1ns / 1ps
// Short queue of code groups between the front and back parts.
// Depends on trp_pkg for the entry type.

module trp_fifo #(
  parameter int unsigned Depth = trp_pkg::FifoDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  trp_pkg::qent_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output trp_pkg::qent_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  trp_pkg::qent_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage, written at the write pointer.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- rtl/trp_front.sv -----
`timescale 1ns / 1ps
// Front part: accepts items, tracks the open run and turns each item into a group of codes.
// Depends on trp_pkg for coding functions and the queue entry type.

module trp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic           command_i,
  input  logic [7:0]     char_byte_i,
  input  logic           line_end_i,
  input  logic           full_i,
  output logic           push_o,
  output trp_pkg::qent_t entry_o
);

  logic [7:0]    run_char_q, run_char_d;
  logic [5:0]    run_len_q, run_len_d;
  logic [7:0]    folded;
  logic [4:0]    cur_code;
  logic          same;
  trp_pkg::grp_t grp_a, grp_b;
  logic [4:0]    shift_a;
  logic          accept;

  assign ready_o  = !full_i;
  assign accept   = valid_i && !full_i;
  assign push_o   = accept;
  assign folded   = trp_pkg::fold_char(char_byte_i);
  assign cur_code = trp_pkg::char_code(run_char_q);
  assign same     = (run_len_q != 6'd0) && (folded == run_char_q);

  // Classify the item: codes from closing or chunking the old run, then from a line end or the end marker of a command.
  always_comb begin
    run_char_d = run_char_q;
    run_len_d  = run_len_q;
    grp_a      = '0;
    grp_b      = '0;
    if (command_i) begin
      grp_a      = trp_pkg::close_run(cur_code, run_len_q);
      grp_b      = '{codes: {trp_pkg::CodeMark, trp_pkg::CodeMark, 5'd0}, cnt: 2'd2};
      run_char_d = 8'd0;
      run_len_d  = 6'd0;
    end else begin
      if (same) begin
        if (run_len_q >= trp_pkg::MaxRunChunk) begin
          grp_a     = trp_pkg::close_run(cur_code, trp_pkg::MaxRunChunk);
          run_len_d = 6'd1;
        end else begin
          run_len_d = run_len_q + 6'd1;
        end
      end else begin
        grp_a      = trp_pkg::close_run(cur_code, run_len_q);
        run_char_d = folded;
        run_len_d  = 6'd1;
      end
      if (line_end_i) begin
        grp_b     = trp_pkg::close_run(trp_pkg::char_code(run_char_d), run_len_d);
        run_len_d = 6'd0;
      end
    end
  end

  // Join the two groups into one left-aligned code list.
  assign shift_a = {1'b0, grp_a.cnt, 2'b00} + {3'b000, grp_a.cnt};
  always_comb begin
    entry_o.codes = {grp_a.codes, 10'd0} | ({grp_b.codes, 10'd0} >> shift_a);
    entry_o.cnt   = {1'b0, grp_a.cnt} + {1'b0, grp_b.cnt};
    entry_o.flush = command_i;
  end

  // Open run state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_char_q <= 8'd0;
      run_len_q  <= 6'd0;
    end else if (accept) begin
      run_char_q <= run_char_d;
      run_len_q  <= run_len_d;
    end
  end

endmodule

// ----- rtl/trp_back.sv -----
`timescale 1ns / 1ps
// Back part: packs queued codes MSB-first behind the pending bits and emits whole bytes.
// Depends on trp_pkg for the queue entry type.

module trp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  trp_pkg::qent_t entry_i,
  output logic           pop_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output logic [7:0]     m_byte_o,
  output logic           m_last_o
);

  logic [6:0]  pend_q;
  logic [2:0]  pcnt_q;
  logic [31:0] sh_q;
  logic [2:0]  left_q;
  logic        ov_q;
  logic [7:0]  ob_q;
  logic        ol_q;

  logic [31:0] acc, rest;
  logic [5:0]  nbits;
  logic [2:0]  nbytes, rem, tot;
  logic [6:0]  pend_d;
  logic [2:0]  pcnt_d;
  logic        out_free, move, pop;

  // Place pending bits and the new codes in one top-aligned word.
  assign acc    = {pend_q, entry_i.codes} << (3'd7 - pcnt_q);
  assign nbits  = {3'd0, pcnt_q} + {1'b0, entry_i.cnt, 2'b00} + {3'd0, entry_i.cnt};
  assign nbytes = nbits[5:3];
  assign rem    = nbits[2:0];
  assign rest   = acc << {nbytes, 3'b000};

  // Leftover bits, and the byte count including the padded end byte.
  always_comb begin
    pend_d = rest[31:25] >> (3'd7 - rem);
    pcnt_d = rem;
    tot    = nbytes;
    if (entry_i.flush) begin
      pend_d = 7'd0;
      pcnt_d = 3'd0;
      if (rem != 3'd0) begin
        tot = nbytes + 3'd1;
      end
    end
  end

  assign out_free = !ov_q || m_ready_i;
  assign move     = out_free && (left_q != 3'd0);
  assign pop      = valid_i && ((left_q == 3'd0) || ((left_q == 3'd1) && out_free));
  assign pop_o    = pop;

  assign m_valid_o = ov_q;
  assign m_byte_o  = ob_q;
  assign m_last_o  = ol_q;

  // Control: pending count, bytes left and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= 3'd0;
      pend_q <= 7'd0;
      left_q <= 3'd0;
      ov_q   <= 1'b0;
    end else begin
      if (move) begin
        ov_q <= 1'b1;
      end else if (m_ready_i) begin
        ov_q <= 1'b0;
      end
      // A new entry replaces the count once the previous item's last byte moves out.
      if (pop) begin
        left_q <= tot;
        pend_q <= pend_d;
        pcnt_q <= pcnt_d;
      end else if (move) begin
        left_q <= left_q - 3'd1;
      end
    end
  end

  // Byte shifter and output register.
  always_ff @(posedge clk_i) begin
    if (move) begin
      ob_q <= sh_q[31:24];
      ol_q <= (left_q == 3'd1);
    end
    if (pop) begin
      sh_q <= acc;
    end else if (move) begin
      sh_q <= sh_q << 8;
    end
  end

endmodule

// ----- rtl/text_rle_5bit_packer.sv -----
`timescale 1ns / 1ps
// Top level of the text run-length packer with 5-bit codes.
// Depends on trp_pkg, trp_front, trp_fifo and trp_back.
//
// Usage:
//   The slave stream carries one item per handshake: tdata is the ASCII character,
//   tlast marks the last character of a line, and tuser set to 1 ends the text
//   (flush, append the end marker and pad the last byte).
//   The master stream carries packed bytes, first code in the top bits; tlast is
//   set on the final byte caused by one input item. Items causing no byte emit nothing.
//   Throughput: one item per cycle while the code queue is not full; the byte shifter
//   in the back part sends the bytes of each entry out one at a time, and the code
//   queue (FifoDepth entries) absorbs bursts of items that produce several bytes.
//   Path: the first byte of an item passes the queue write at the edge that accepts
//   it, then the shifter load, then the output register.
//   Reset clears the open run, the pending bits and the queue; the next item starts
//   a new text. When the receiver stalls, the output register holds its byte, the
//   queue fills and s_axis_tready drops once it is full.

module text_rle_5bit_packer #(
  parameter int unsigned FifoDepth = trp_pkg::FifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
  input  logic       s_axis_tlast,   // line_end
  input  logic       s_axis_tuser,   // [0] command
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // last_of_item
);

  trp_pkg::qent_t push_entry, pop_entry;
  logic           push, full, q_valid, pop;

  // Front part: run tracking and code grouping.
  trp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid),
    .ready_o    (s_axis_tready),
    .command_i  (s_axis_tuser),
    .char_byte_i(s_axis_tdata),
    .line_end_i (s_axis_tlast),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // Queue of code groups.
  trp_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(push_entry),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .rdata_o(pop_entry)
  );

  // Back part: bit packing and byte output.
  trp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .entry_i  (pop_entry),
    .pop_o    (pop),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_byte_o (m_axis_tdata),
    .m_last_o (m_axis_tlast)
  );

endmodule

// ----- tb/trp_stream_check.sv -----
`timescale 1ns / 1ps
// Stream checker for the text run-length packer: predicts the packed bytes of every
// accepted item and compares them with the bytes leaving the block. Depends on trp_pkg.

module trp_stream_check (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_char_i,
  input  logic       in_line_end_i,
  input  logic       in_text_end_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_byte_i,
  input  logic       out_last_i,
  output int         fail_count_o,
  output int         backlog_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } packed_byte_t;

  // Predicted encoder state.
  logic [7:0] run_char_q;
  logic [5:0] run_len_q;
  logic [6:0] pend_bits_q;
  logic [2:0] pend_cnt_q;

  packed_byte_t expected_bytes[$];
  logic [7:0]   item_bytes[$];
  int           mismatches;
  int           backlog;

  assign fail_count_o = mismatches;
  assign backlog_o    = backlog;

  function automatic void flag_error(string msg);
    if (mismatches < 10) begin
      $display("%0t: mismatch: %s", $time, msg);
    end
    mismatches++;
  endfunction

  // Lower-case letters fold to upper case; everything else passes unchanged.
  function automatic logic [7:0] upcase(logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'd32;
    end
    return c;
  endfunction

  // Five-bit code of a folded character.
  function automatic logic [4:0] code_of(logic [7:0] c);
    logic [4:0] code;
    code = trp_pkg::CodeMark;
    if (c >= 8'h41 && c <= 8'h5A) begin
      code = 5'(c - 8'h41);
    end else if (c == 8'h20) begin
      code = trp_pkg::CodeSpace;
    end else if (c == 8'h2E) begin
      code = trp_pkg::CodePeriod;
    end else if (c == 8'h2C) begin
      code = trp_pkg::CodeComma;
    end else if (c == 8'h0A) begin
      code = trp_pkg::CodeNewline;
    end else if (c == 8'h3F) begin
      code = trp_pkg::CodeQuestion;
    end
    return code;
  endfunction

  // Append one code to the bit accumulator; a full byte goes to the item's output list.
  function automatic void pack_code(logic [4:0] code);
    logic [11:0] acc;
    int          cnt;
    acc = {pend_bits_q, code};
    cnt = pend_cnt_q + 5;
    if (cnt >= 8) begin
      cnt -= 8;
      item_bytes.push_back(8'(acc >> cnt));
    end
    pend_bits_q = 7'(acc & ((12'd1 << cnt) - 12'd1));
    pend_cnt_q  = 3'(cnt);
  endfunction

  function automatic void write_run_triple(logic [4:0] code, logic [5:0] len);
    pack_code(trp_pkg::CodeMark);
    pack_code(code);
    pack_code(5'(len - 6'd3));
  endfunction

  // Close the open run: long runs as a triple, short ones as literals, mark codes dropped.
  function automatic void close_open_run();
    logic [4:0] code;
    code = code_of(run_char_q);
    if (run_len_q != 0 && code != trp_pkg::CodeMark) begin
      if (run_len_q >= trp_pkg::MinRun) begin
        write_run_triple(code, run_len_q);
      end else begin
        for (int i = 0; i < run_len_q; i++) begin
          pack_code(code);
        end
      end
    end
    run_len_q = '0;
  endfunction

  function automatic void clear_state();
    run_char_q  = '0;
    run_len_q   = '0;
    pend_bits_q = '0;
    pend_cnt_q  = '0;
  endfunction

  // Work out the bytes that one accepted item produces and queue them.
  function automatic void predict_item(logic text_end, logic [7:0] ch, logic line_end);
    logic [7:0] f;
    item_bytes.delete();
    if (text_end) begin
      close_open_run();
      pack_code(trp_pkg::CodeMark);
      pack_code(trp_pkg::CodeMark);
      if (pend_cnt_q != 0) begin
        item_bytes.push_back(8'({1'b0, pend_bits_q} << (8 - pend_cnt_q)));
      end
      clear_state();
    end else begin
      f = upcase(ch);
      if (run_len_q != 0 && f == run_char_q) begin
        if (run_len_q >= trp_pkg::MaxRunChunk) begin
          // A full chunk is written out and the run carries on.
          if (code_of(run_char_q) != trp_pkg::CodeMark) begin
            write_run_triple(code_of(run_char_q), trp_pkg::MaxRunChunk);
          end
          run_len_q = 6'd1;
        end else begin
          run_len_q = run_len_q + 6'd1;
        end
      end else begin
        close_open_run();
        run_char_q = f;
        run_len_q  = 6'd1;
      end
      if (line_end) begin
        close_open_run();
      end
    end
    foreach (item_bytes[i]) begin
      expected_bytes.push_back('{data: item_bytes[i], last: (i == item_bytes.size() - 1)});
    end
  endfunction

  // Compare leaving bytes first, then predict the item accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    packed_byte_t want;
    if (!rst_ni) begin
      clear_state();
      expected_bytes.delete();
      mismatches = 0;
      backlog    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          flag_error($sformatf("unexpected byte %02h last %0b", out_byte_i, out_last_i));
        end else begin
          want = expected_bytes.pop_front();
          if (want.data !== out_byte_i || want.last !== out_last_i) begin
            flag_error($sformatf("byte exp %02h got %02h, last exp %0b got %0b",
                                 want.data, out_byte_i, want.last, out_last_i));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_item(in_text_end_i, in_char_i, in_line_end_i);
      end
      backlog = expected_bytes.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for text_rle_5bit_packer: clock, reset, character stimulus and the
// output-side ready pattern. Depends on the block's RTL and on trp_stream_check.

module tb_top;

  logic       clk;
  logic       rst_n;
  logic       s_valid;
  logic       s_ready;
  logic [7:0] s_char;
  logic       s_line_end;
  logic       s_text_end;
  logic       m_valid;
  logic       m_ready;
  logic [7:0] m_byte;
  logic       m_last;

  int fails;
  int backlog;
  int phase;
  int sent;
  bit hold_req;

  text_rle_5bit_packer dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_char),
    .s_axis_tlast  (s_line_end),
    .s_axis_tuser  (s_text_end),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_byte),
    .m_axis_tlast  (m_last)
  );

  trp_stream_check pack_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (s_valid),
    .in_ready_i    (s_ready),
    .in_char_i     (s_char),
    .in_line_end_i (s_line_end),
    .in_text_end_i (s_text_end),
    .out_valid_i   (m_valid),
    .out_ready_i   (m_ready),
    .out_byte_i    (m_byte),
    .out_last_i    (m_last),
    .fail_count_o  (fails),
    .backlog_o     (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle percentages per phase: sender light first, then heavy, then none at all.
  function automatic int tx_idle_pct();
    return (phase == 0) ? 18 : (phase == 1) ? 45 : 0;
  endfunction

  function automatic int rx_idle_pct();
    return (phase == 0) ? 45 : (phase == 1) ? 18 : 0;
  endfunction

  // Receiver: random stalls, plus one long hold-off once requested.
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    m_ready    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 300;
      end
      if (hold_left > 0) begin
        m_ready <= 1'b0;
        hold_left--;
      end else begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct());
      end
    end
  end

  // Offer one item and wait until the block takes it.
  task automatic send_item(logic text_end, logic [7:0] ch, logic line_end);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct()) begin
      s_valid <= 1'b0;
      @(negedge clk);
    end
    s_valid    <= 1'b1;
    s_text_end <= text_end;
    s_char     <= ch;
    s_line_end <= line_end;
    do @(posedge clk); while (!s_ready);
    sent++;
  endtask

  task automatic send_text_end();
    send_item(1'b1, 8'($urandom), 1'($urandom));
  endtask

  // Short hand-picked text: folding, every coded non-letter symbol, mark characters and run edges.
  task automatic send_directed_text();
    logic [7:0] specials[5];
    specials = '{8'h20, 8'h2E, 8'h2C, 8'h0A, 8'h3F};
    // Empty text: only the end marker.
    send_text_end();
    // Run of four with mixed case, closed by a line end.
    send_item(1'b0, 8'h61, 1'b0);
    send_item(1'b0, 8'h41, 1'b0);
    send_item(1'b0, 8'h61, 1'b0);
    send_item(1'b0, 8'h41, 1'b1);
    // Run of three written as literals, broken by a new character.
    send_item(1'b0, 8'h7A, 1'b0);
    send_item(1'b0, 8'h5A, 1'b0);
    send_item(1'b0, 8'h7A, 1'b0);
    send_item(1'b0, 8'h71, 1'b0);
    foreach (specials[i]) begin
      send_item(1'b0, specials[i], i == 4);
    end
    // Characters with the mark code make runs but write nothing.
    send_item(1'b0, 8'h00, 1'b0);
    send_item(1'b0, 8'hFF, 1'b0);
    send_item(1'b0, 8'hFF, 1'b0);
    send_item(1'b0, 8'h7F, 1'b1);
    // A line end splits a run of equal characters.
    send_item(1'b0, 8'h42, 1'b0);
    send_item(1'b0, 8'h42, 1'b1);
    send_item(1'b0, 8'h42, 1'b0);
    send_text_end();
  endtask

  // A run of one character; letters flip case at random, which folding undoes.
  task automatic send_run(logic [7:0] ch, int len, bit close_line);
    for (int i = 0; i < len; i++) begin
      logic [7:0] c;
      logic       le;
      c = ch;
      if (ch >= 8'h41 && ch <= 8'h5A && $urandom_range(1) == 1) begin
        c = ch ^ 8'h20;
      end
      le = (close_line && i == len - 1) || ($urandom_range(99) < 3);
      send_item(1'b0, c, le);
    end
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      return 8'h41 + 8'($urandom_range(25));
    end else if (r < 85) begin
      case ($urandom_range(4))
        0: return 8'h20;
        1: return 8'h2E;
        2: return 8'h2C;
        3: return 8'h0A;
        default: return 8'h3F;
      endcase
    end
    return 8'($urandom);
  endfunction

  function automatic int pick_run_len();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $urandom_range(3, 1);
    if (r < 80) return $urandom_range(8, 4);
    if (r < 95) return $urandom_range(36, 9);
    return $urandom_range(72, 30);
  endfunction

  // Mostly runs of text with random content, with noise items and early text ends.
  task automatic send_random_text(int count);
    int start;
    int r;
    start = sent;
    // Runs around the chunk limit first.
    send_run(pick_char(), 34, 1'b1);
    send_run(pick_char(), 35, 1'b0);
    send_run(pick_char(), 69, 1'b1);
    while (sent - start < count) begin
      if (sent - start >= (2 * count) / 3) begin
        phase    = 2;
        hold_req = 1'b1;
      end else if (sent - start >= count / 3) begin
        phase = 1;
      end
      r = $urandom_range(99);
      if (r < 6) begin
        send_text_end();
      end else if (r < 14) begin
        send_item($urandom_range(99) < 10, 8'($urandom), 1'($urandom));
      end else begin
        send_run(pick_char(), pick_run_len(), $urandom_range(99) < 30);
      end
    end
    send_text_end();
  endtask

  initial begin
    s_valid    = 1'b0;
    s_char     = '0;
    s_line_end = 1'b0;
    s_text_end = 1'b0;
    phase      = 0;
    sent       = 0;
    hold_req   = 1'b0;
    rst_n      = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    send_directed_text();
    send_random_text(500);
    @(negedge clk);
    s_valid <= 1'b0;
    // Drain the expected bytes, then keep watching for stray output.
    while (backlog != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0 && backlog == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
